// ===== rtl/tsidf_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tsidf_pkg
// widths, register indexes and pipeline bookkeeping for the two-source
// inverse-distance field core
// ---------------------------------------------------------------------------
package tsidf_pkg;

  localparam int unsigned DIMENSIONS = 3;

  localparam int unsigned DW         = 32;  // q16.16 word
  localparam int unsigned DISP_W     = 33;  // exact displacement
  localparam int unsigned SQ_W       = 66;  // squared distance, q32.32
  localparam int unsigned AP_W       = 63;  // |amp| * |d|
  localparam int unsigned R_W        = 33;  // distance, raw units
  localparam int unsigned RR_W       = 66;  // r * r
  localparam int unsigned R3_W       = 99;  // r ^ 3
  localparam int unsigned NUM_W      = 95;  // dividend
  localparam int unsigned DEN_W      = 99;  // divisor
  localparam int unsigned QUO_W      = 65;  // quotient, one bit per stage
  localparam int unsigned SQRT_STEPS = 33;  // one root bit per stage
  localparam int unsigned SQRT_REM_W = 35;
  localparam int unsigned TERM_W     = 66;
  localparam int unsigned SUM_W      = 67;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_AMP_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMP_B   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_A_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_A_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_A_Z = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_B_X = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_B_Y = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_B_Z = 3'd7;

  // front stages, root stages, cube stages, divide stages, sum, output
  localparam int unsigned NSTAGE = 4 + SQRT_STEPS + 3 + QUO_W + 2;

  // sideband carried alongside the root extraction
  typedef struct packed {
    logic [1:0][2:0][AP_W-1:0] ap;
    logic [1:0][2:0]           dneg;
    logic                      sing;
  } side_t;

  // sideband carried alongside the dividers
  typedef struct packed {
    logic [1:0][2:0] dneg;
    logic            sing;
  } fin_t;

endpackage
`default_nettype wire

// ===== rtl/tsidf_sqrt.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tsidf_sqrt
// pipelined integer square root, one root bit per stage (floor)
// ---------------------------------------------------------------------------
module tsidf_sqrt import tsidf_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [SQ_W-1:0] rad_i,
  output logic      [R_W-1:0]  root_o
);

  logic [SQRT_REM_W-1:0] rem_q  [SQRT_STEPS-1];
  logic [SQ_W-1:0]       rad_q  [SQRT_STEPS-1];
  logic [R_W-1:0]        root_q [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [SQRT_REM_W-1:0] rem_in;
    logic [SQ_W-1:0]       rad_in;
    logic [R_W-1:0]        root_in;
    logic [SQRT_REM_W+1:0] remx;
    logic [SQRT_REM_W+1:0] trial;
    logic                  ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign rad_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign root_in = root_q[k-1];
    end

    // bring down the next two radicand bits and try root*4+1
    assign remx  = {rem_in, rad_in[SQ_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = (remx >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= {root_in[R_W-2:0], ge};
      end
    end

    if (k < SQRT_STEPS - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? SQRT_REM_W'(remx - trial) : SQRT_REM_W'(remx);
          rad_q[k] <= {rad_in[SQ_W-3:0], 2'b00};
        end
      end
    end
  end

  assign root_o = root_q[SQRT_STEPS-1];

endmodule
`default_nettype wire

// ===== rtl/tsidf_div.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tsidf_div
// pipelined restoring divider, one quotient bit per stage
// ---------------------------------------------------------------------------
module tsidf_div import tsidf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic      [QUO_W-1:0] quo_o
);

  // quotient is known to fit QUO_W bits, so the high dividend bits seed the remainder
  logic [DEN_W-1:0] rem_q [QUO_W-1];
  logic [DEN_W-1:0] den_q [QUO_W-1];
  logic [QUO_W-1:0] nq_q  [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] nq_in;
    logic [DEN_W:0]   remx;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = DEN_W'(num_i[NUM_W-1:QUO_W]);
      assign den_in = den_i;
      assign nq_in  = num_i[QUO_W-1:0];
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign nq_in  = nq_q[k-1];
    end

    assign remx = {rem_in, nq_in[QUO_W-1]};
    assign ge   = (remx >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[k] <= {nq_in[QUO_W-2:0], ge};
      end
    end

    if (k < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? DEN_W'(remx - {1'b0, den_in}) : remx[DEN_W-1:0];
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign quo_o = nq_q[QUO_W-1];

endmodule
`default_nettype wire

// ===== rtl/two_source_inverse_distance_field_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// two_source_inverse_distance_field_core
// potential and gradient of two inverse-distance point sources, q16.16
// ---------------------------------------------------------------------------
//  channel   direction  handshake                      request
//  s_axis    in         s_axis_tvalid / s_axis_tready  one grid point
//  m_axis    out        m_axis_tvalid / m_axis_tready  potential, gradient, flags
//  cfg       in         cfg_valid_i / cfg_ready_o      one register write
//
//  one point per cycle while the output is not stalled; depth NSTAGE, set by the 33-stage
//  square root and the 65-stage dividers, one bit per stage
//  the whole pipeline holds while a finished request waits at the output;
//  the output register lets a new point in on the cycle the result leaves
//  reset clears the valid bits and the configuration registers; no clearing pass
// ---------------------------------------------------------------------------
module two_source_inverse_distance_field_core import tsidf_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // point: pos_x, pos_y, pos_z from bit 0 up
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [3*DW-1:0]      s_axis_tdata,
  // result: potential, grad_x, grad_y, grad_z from bit 0 up
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic      [4*DW-1:0]      m_axis_tdata,
  // flags: singular, saturated from bit 0 up
  output logic      [1:0]           m_axis_tuser,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [DW-1:0]        cfg_data_i
);

  // configuration
  logic signed [DW-1:0] amp_q [2];
  logic signed [DW-1:0] src_q [2][3];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < 2; s++) begin
        amp_q[s] <= '0;
        for (int i = 0; i < 3; i++) src_q[s][i] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_AMP_A:   amp_q[0]    <= cfg_data_i;
        CFG_AMP_B:   amp_q[1]    <= cfg_data_i;
        CFG_SRC_A_X: src_q[0][0] <= cfg_data_i;
        CFG_SRC_A_Y: src_q[0][1] <= cfg_data_i;
        CFG_SRC_A_Z: src_q[0][2] <= cfg_data_i;
        CFG_SRC_B_X: src_q[1][0] <= cfg_data_i;
        CFG_SRC_B_Y: src_q[1][1] <= cfg_data_i;
        CFG_SRC_B_Z: src_q[1][2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // amp magnitude and sign; user changes registers only while the pipe is empty, unchecked
  logic [DW-1:0] amag [2];
  logic          aneg [2];
  always_comb begin
    for (int s = 0; s < 2; s++) begin
      aneg[s] = amp_q[s][DW-1];
      amag[s] = aneg[s] ? DW'(-amp_q[s]) : DW'(amp_q[s]);
    end
  end

  // pipeline advance and valid bits
  logic              en;
  logic [NSTAGE-1:0] vld_q;

  assign en            = !vld_q[NSTAGE-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[NSTAGE-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTAGE-2:0], s_axis_tvalid};
    end
  end

  // stage 1: displacement, unused dimensions forced to zero
  logic signed [DISP_W-1:0] d1_q [2][3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < 2; s++) begin
        for (int i = 0; i < 3; i++) begin
          if (i < DIMENSIONS) begin
            d1_q[s][i] <= $signed({s_axis_tdata[i*DW+DW-1], s_axis_tdata[i*DW +: DW]})
                        - $signed({src_q[s][i][DW-1], src_q[s][i]});
          end else begin
            d1_q[s][i] <= '0;
          end
        end
      end
    end
  end

  // stage 2: magnitude and sign
  logic [DISP_W-1:0] mag2_q  [2][3];
  logic              dneg2_q [2][3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < 2; s++) begin
        for (int i = 0; i < 3; i++) begin
          dneg2_q[s][i] <= d1_q[s][i][DISP_W-1];
          mag2_q[s][i]  <= d1_q[s][i][DISP_W-1] ? DISP_W'(-d1_q[s][i])
                                                 : DISP_W'(d1_q[s][i]);
        end
      end
    end
  end

  // stage 3: squares and amplitude products
  logic [SQ_W-1:0]      sq3_q [2][3];
  side_t                side3_q;
  logic [DW+DISP_W-1:0] apf   [2][3];
  logic [1:0]           zero2;
  always_comb begin
    for (int s = 0; s < 2; s++) begin
      zero2[s] = 1'b1;
      for (int i = 0; i < 3; i++) begin
        apf[s][i] = amag[s] * mag2_q[s][i];
        if (mag2_q[s][i] != '0) zero2[s] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < 2; s++) begin
        for (int i = 0; i < 3; i++) begin
          sq3_q[s][i]        <= mag2_q[s][i] * mag2_q[s][i];
          side3_q.ap[s][i]   <= AP_W'(apf[s][i]);
          side3_q.dneg[s][i] <= dneg2_q[s][i];
        end
      end
      // point on a source
      side3_q.sing <= zero2[0] || zero2[1];
    end
  end

  // stage 4: squared distance
  logic [SQ_W-1:0] r2_4_q [2];
  side_t           side4_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < 2; s++) begin
        r2_4_q[s] <= sq3_q[s][0] + sq3_q[s][1] + sq3_q[s][2];
      end
      side4_q <= side3_q;
    end
  end

  // root extraction
  logic [R_W-1:0] root [2];
  side_t          sd_q [SQRT_STEPS];

  for (genvar s = 0; s < 2; s++) begin : g_sqrt
    tsidf_sqrt u_sqrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .rad_i  (r2_4_q[s]),
      .root_o (root[s])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= side4_q;
      for (int k = 1; k < SQRT_STEPS; k++) sd_q[k] <= sd_q[k-1];
    end
  end

  // stages 5 to 7: r cubed, upper product split in two halves
  logic [RR_W-1:0] rr5_q  [2];
  logic [R_W-1:0]  r5_q   [2];
  side_t           side5_q;
  logic [RR_W-1:0] plo6_q [2];
  logic [RR_W-1:0] phi6_q [2];
  logic [R_W-1:0]  r6_q   [2];
  side_t           side6_q;
  logic [R3_W-1:0] r3_7_q [2];
  logic [R_W-1:0]  r7_q   [2];
  side_t           side7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < 2; s++) begin
        rr5_q[s]  <= root[s] * root[s];
        r5_q[s]   <= root[s];
        plo6_q[s] <= rr5_q[s][R_W-1:0] * r5_q[s];
        phi6_q[s] <= rr5_q[s][RR_W-1:R_W] * r5_q[s];
        r6_q[s]   <= r5_q[s];
        r3_7_q[s] <= R3_W'(plo6_q[s]) + {phi6_q[s], {R_W{1'b0}}};
        r7_q[s]   <= r6_q[s];
      end
      side5_q <= sd_q[SQRT_STEPS-1];
      side6_q <= side5_q;
      side7_q <= side6_q;
    end
  end

  // dividers: potential is |a|*2^16/r, gradient is |a|*|d|*2^32/r^3
  logic [QUO_W-1:0] qp [2];
  logic [QUO_W-1:0] qg [2][3];
  fin_t             fd_q [QUO_W];

  for (genvar s = 0; s < 2; s++) begin : g_src
    tsidf_div u_div_pot (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i ({{(NUM_W-DW-16){1'b0}}, amag[s], 16'b0}),
      .den_i (DEN_W'(r7_q[s])),
      .quo_o (qp[s])
    );
    for (genvar i = 0; i < 3; i++) begin : g_dim
      tsidf_div u_div_grad (
        .clk_i (clk_i),
        .en_i  (en),
        .num_i ({side7_q.ap[s][i], 32'b0}),
        .den_i (r3_7_q[s]),
        .quo_o (qg[s][i])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fd_q[0].dneg <= side7_q.dneg;
      fd_q[0].sing <= side7_q.sing;
      for (int k = 1; k < QUO_W; k++) fd_q[k] <= fd_q[k-1];
    end
  end

  // sum stage: signed terms, exact sums
  logic signed [TERM_W-1:0] tp [2];
  logic signed [TERM_W-1:0] tg [2][3];
  logic signed [SUM_W-1:0]  pot_sum_q;
  logic signed [SUM_W-1:0]  grad_sum_q [3];
  logic                     sing_f_q;
  fin_t                     fin;

  assign fin = fd_q[QUO_W-1];

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      tp[s] = aneg[s] ? -$signed({1'b0, qp[s]}) : $signed({1'b0, qp[s]});
      for (int i = 0; i < 3; i++) begin
        // term is negative when amplitude and displacement share a sign
        tg[s][i] = (aneg[s] == fin.dneg[s][i]) ? -$signed({1'b0, qg[s][i]})
                                               : $signed({1'b0, qg[s][i]});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pot_sum_q <= SUM_W'(tp[0]) + SUM_W'(tp[1]);
      for (int i = 0; i < 3; i++) grad_sum_q[i] <= SUM_W'(tg[0][i]) + SUM_W'(tg[1][i]);
      sing_f_q <= fin.sing;
    end
  end

  // clip to 32 bits, flag in the top bit
  function automatic logic [DW:0] sat32(input logic signed [SUM_W-1:0] v);
    logic [DW:0] res;
    if (v > SUM_W'(signed'(33'sh07FFFFFFF))) begin
      res = {1'b1, 32'h7FFF_FFFF};
    end else if (v < SUM_W'(signed'(33'sh180000000))) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, v[DW-1:0]};
    end
    return res;
  endfunction

  // output register
  logic [DW:0] sp;
  logic [DW:0] sg [3];
  always_comb begin
    sp = sat32(pot_sum_q);
    for (int i = 0; i < 3; i++) sg[i] = sat32(grad_sum_q[i]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (sing_f_q) begin
        m_axis_tdata <= '0;
        m_axis_tuser <= 2'b01;
      end else begin
        m_axis_tdata <= {sg[2][DW-1:0], sg[1][DW-1:0], sg[0][DW-1:0], sp[DW-1:0]};
        m_axis_tuser <= {sp[DW] | sg[0][DW] | sg[1][DW] | sg[2][DW], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the two-source inverse-distance field core: grid
// points are streamed in under several idle and stall patterns and every
// result is compared against a bit-exact q16.16 field predictor
// ---------------------------------------------------------------------------
module tb import tsidf_pkg::*;;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES   = NSTAGE + 20;

  typedef struct packed {
    logic signed [DW-1:0] z;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] x;
  } point_t;

  typedef struct packed {
    logic              saturated;
    logic              singular;
    logic [DW-1:0]     gz;
    logic [DW-1:0]     gy;
    logic [DW-1:0]     gx;
    logic [DW-1:0]     pot;
  } field_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [3*DW-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [4*DW-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DW-1:0] cfg_data_i;

  two_source_inverse_distance_field_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // predictor's copy of the configuration
  logic signed [DW-1:0] amp_q [2];
  logic signed [DW-1:0] src_q [2][3];

  point_t pending_points [$];
  field_t expected_fields [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  bit          hold_off;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // saturate a wide signed sum to q16.16, flagging any clip
  function automatic logic [DW-1:0] clip32(input logic signed [SUM_W+40:0] v,
                                           inout logic sat);
    if (v > 64'sh7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[DW-1:0];
  endfunction

  // bit-exact field at one point: exact terms, each truncated toward zero
  function automatic field_t field_at(input point_t p);
    field_t f;
    logic signed [DW:0]       disp [2][3];
    logic [SQ_W+1:0]          dist2 [2];
    logic [R_W+1:0]           root, trial;
    logic [2*R_W+5:0]         tsq;
    logic [R3_W+2:0]          cube;
    logic [SUM_W+40:0]        mag;
    logic signed [SUM_W+40:0] pot_sum;
    logic signed [SUM_W+40:0] grad_sum [3];
    logic [DW:0]              amag, dmag;
    logic [NUM_W+40:0]        num;
    logic                     neg, sat;
    logic signed [DW-1:0]     coord [3];
    f = '0;
    sat = 1'b0;
    coord[0] = p.x; coord[1] = p.y; coord[2] = p.z;
    for (int s = 0; s < 2; s++) begin
      dist2[s] = '0;
      for (int i = 0; i < 3; i++) begin
        disp[s][i] = (i < DIMENSIONS) ? ($signed({coord[i][DW-1], coord[i]}) -
                      $signed({src_q[s][i][DW-1], src_q[s][i]})) : '0;
        dmag = disp[s][i][DW] ? -disp[s][i] : disp[s][i];
        dist2[s] += dmag * dmag;
      end
    end
    if (dist2[0] == 0 || dist2[1] == 0) begin
      f.singular = 1'b1;
      return f;
    end
    pot_sum = '0;
    for (int i = 0; i < 3; i++) grad_sum[i] = '0;
    for (int s = 0; s < 2; s++) begin
      root = '0;
      for (int b = 34; b >= 0; b--) begin
        trial = root | (35'd1 << b);
        tsq = trial * trial;
        if (tsq <= dist2[s]) root = trial;
      end
      cube = root * root * root;
      amag = amp_q[s][DW-1] ? -$signed({1'b1, amp_q[s]}) : {1'b0, amp_q[s]};
      mag = ({amag, 16'h0}) / root;
      pot_sum += amp_q[s][DW-1] ? -$signed(mag) : $signed(mag);
      for (int i = 0; i < DIMENSIONS; i++) begin
        dmag = disp[s][i][DW] ? -disp[s][i] : disp[s][i];
        num = (amag * dmag) << 32;
        mag = num / cube;
        neg = (amp_q[s][DW-1] == disp[s][i][DW]);
        grad_sum[i] += neg ? -$signed(mag) : $signed(mag);
      end
    end
    f.pot = clip32(pot_sum, sat);
    f.gx  = clip32(grad_sum[0], sat);
    f.gy  = clip32(grad_sum[1], sat);
    f.gz  = clip32(grad_sum[2], sat);
    f.saturated = sat;
    return f;
  endfunction

  // accepted request seen at the last rising edge
  logic s_axis_tready_q;
  logic cfg_done_q;
  always @(posedge clk_i) begin
    s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
    cfg_done_q      <= cfg_valid_i && cfg_ready_o;
  end

  // driver: one point from the queue, new values at the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready_q) begin
      if (pending_points.size() > 0 && !hold_off &&
          $urandom_range(99) >= send_idle_pct) begin
        s_axis_tdata  <= pending_points.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: predict on accepted points, check accepted results
  always @(posedge clk_i) begin
    field_t got, exp_f;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_fields.push_back(field_at(point_t'(s_axis_tdata)));
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata};
        if (expected_fields.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          exp_f = expected_fields.pop_front();
          if (got !== exp_f) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: pot %h/%h gx %h/%h gy %h/%h gz %h/%h sing %b/%b sat %b/%b",
                       exp_f.pot, got.pot, exp_f.gx, got.gx, exp_f.gy, got.gy,
                       exp_f.gz, got.gz, exp_f.singular, got.singular,
                       exp_f.saturated, got.saturated);
          end
        end
      end
      // watchdog on handshake activity
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DW-1:0] val);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(negedge clk_i); while (!cfg_done_q);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_AMP_A) amp_q[0] = val;
    else if (idx == CFG_AMP_B) amp_q[1] = val;
    else if (idx <= CFG_SRC_A_Z) src_q[0][idx - CFG_SRC_A_X] = val;
    else src_q[1][idx - CFG_SRC_B_X] = val;
  endtask

  task automatic wait_idle();
    while (pending_points.size() > 0 || s_axis_tvalid || expected_fields.size() > 0)
      @(negedge clk_i);
  endtask

  // random value, biased towards small magnitudes and the extremes
  function automatic logic [DW-1:0] rand_word();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return $signed($urandom_range(4000)) - 2000;
      default: return ($signed($urandom_range(2_000_000)) - 1_000_000) <<< $urandom_range(4);
    endcase
  endfunction

  task automatic add_point(input logic [DW-1:0] x, y, z);
    point_t p;
    p.x = x; p.y = y; p.z = z;
    pending_points.push_back(p);
  endtask

  initial begin
    logic [DW-1:0] regs [8];
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_AMP_A;
    cfg_data_i = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b0;
    mismatches = 0;
    quiet_cycles = 0;
    for (int s = 0; s < 2; s++) begin
      amp_q[s] = '0;
      for (int i = 0; i < 3; i++) src_q[s][i] = '0;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset configuration: every point off the origin is a zero field
    add_point(32'h0, 32'h0, 32'h0);
    add_point(32'h0001_0000, 32'h0, 32'h0);
    wait_idle();

    // directed: unit sources, on-source points, extremes, saturation
    write_reg(CFG_AMP_A, 32'h0001_0000);
    write_reg(CFG_AMP_B, 32'hFFFF_0000);
    write_reg(CFG_SRC_A_X, 32'h0001_0000);
    write_reg(CFG_SRC_A_Y, 32'h0);
    write_reg(CFG_SRC_A_Z, 32'h0);
    write_reg(CFG_SRC_B_X, 32'hFFFF_0000);
    write_reg(CFG_SRC_B_Y, 32'h0);
    write_reg(CFG_SRC_B_Z, 32'h0);
    add_point(32'h0001_0000, 32'h0, 32'h0);
    add_point(32'hFFFF_0000, 32'h0, 32'h0);
    add_point(32'h0, 32'h0, 32'h0);
    add_point(32'h0001_0001, 32'h0, 32'h0);
    add_point(32'h0, 32'h0001_0000, 32'h0);
    add_point(32'h0, 32'h0, 32'hFFFF_0000);
    add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    wait_idle();
    write_reg(CFG_AMP_A, 32'h7FFF_FFFF);
    write_reg(CFG_AMP_B, 32'h8000_0000);
    write_reg(CFG_SRC_A_X, 32'h8000_0000);
    write_reg(CFG_SRC_B_Z, 32'h7FFF_FFFF);
    add_point(32'h8000_0001, 32'h0, 32'h0);
    add_point(32'h8000_0000, 32'h0, 32'h1);
    add_point(32'h0, 32'h0, 32'h7FFF_FFFE);
    add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    add_point(32'h0, 32'h1, 32'h7FFF_FFFF);
    add_point(32'h8000_0000, 32'h0, 32'h0);
    wait_idle();

    // random phases, each with a fresh configuration and one of four idle and stall patterns
    for (int ph = 0; ph < 8; ph++) begin
      for (int r = 0; r < 8; r++) regs[r] = rand_word();
      for (int r = 0; r < 8; r++) write_reg(r[CFG_IDX_W-1:0], regs[r]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      for (int n = 0; n < 215; n++) begin
        case ($urandom_range(9))
          0: add_point(src_q[0][0], src_q[0][1], src_q[0][2]);
          1: add_point(src_q[1][0], src_q[1][1], src_q[1][2]);
          2: add_point(src_q[0][0] + ($urandom_range(2) - 1), src_q[0][1],
                       src_q[0][2] + ($urandom_range(2) - 1));
          default: add_point(rand_word(), rand_word(), rand_word());
        endcase
        // sender waits out the whole pipeline once per phase
        if (n == 100) begin
          while (pending_points.size() > 0 || s_axis_tvalid) @(negedge clk_i);
          hold_off = 1'b1;
          while (expected_fields.size() > 0) @(negedge clk_i);
          hold_off = 1'b0;
        end
      end
      wait_idle();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatches == 0 && expected_fields.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
